### hdl/sccld_pkg.sv
`default_nettype none
package sccld_pkg;

    localparam int STORE_DEPTH_DEF = 12;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int DECODE_COUNT    = 10;
    localparam int SLOT_COUNT      = 31;
    localparam int PIN_COUNT       = 7;
    localparam int DIGIT_BITS      = 24;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_B     = 8'h42;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [PIN_COUNT-1:0] drive_mask;
        logic [PIN_COUNT-1:0] level_mask;
        logic [4:0]           slot;
    } t_out_item;

    typedef struct packed {
        logic       is_tick;
        logic       is_colon;
        logic       is_b;
        logic [3:0] nib;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef struct packed {
        logic [2:0] lo;
        logic [2:0] hi;
    } t_pin_pair;

    function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
        logic [3:0] n;
        n = 4'd0;
        if (ch inside {[8'h30:8'h39]}) begin
            n = ch[3:0];
        end else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            n = ch[3:0] + 4'd9;
        end
        return n;
    endfunction

    function automatic logic [2:0] ind_of_slot(input logic [2:0] k);
        logic [2:0] b;
        case (k)
            3'd0: b = 3'd0;
            3'd1: b = 3'd2;
            3'd2: b = 3'd1;
            3'd3: b = 3'd3;
            3'd4: b = 3'd4;
            3'd5: b = 3'd5;
            3'd6: b = 3'd6;
            default: b = 3'd0;
        endcase
        return b;
    endfunction

    function automatic t_pin_pair slot_pins(input logic [4:0] s);
        t_pin_pair p;
        case (s)
            5'd0:  p = '{lo: 3'd0, hi: 3'd1};
            5'd1:  p = '{lo: 3'd0, hi: 3'd2};
            5'd2:  p = '{lo: 3'd3, hi: 3'd0};
            5'd3:  p = '{lo: 3'd4, hi: 3'd0};
            5'd4:  p = '{lo: 3'd0, hi: 3'd3};
            5'd5:  p = '{lo: 3'd1, hi: 3'd0};
            5'd6:  p = '{lo: 3'd2, hi: 3'd0};
            5'd7:  p = '{lo: 3'd4, hi: 3'd5};
            5'd8:  p = '{lo: 3'd1, hi: 3'd2};
            5'd9:  p = '{lo: 3'd1, hi: 3'd3};
            5'd10: p = '{lo: 3'd4, hi: 3'd1};
            5'd11: p = '{lo: 3'd1, hi: 3'd5};
            5'd12: p = '{lo: 3'd1, hi: 3'd4};
            5'd13: p = '{lo: 3'd2, hi: 3'd1};
            5'd14: p = '{lo: 3'd3, hi: 3'd1};
            5'd15: p = '{lo: 3'd2, hi: 3'd5};
            5'd16: p = '{lo: 3'd4, hi: 3'd3};
            5'd17: p = '{lo: 3'd2, hi: 3'd4};
            5'd18: p = '{lo: 3'd3, hi: 3'd4};
            5'd19: p = '{lo: 3'd5, hi: 3'd0};
            5'd20: p = '{lo: 3'd5, hi: 3'd2};
            5'd21: p = '{lo: 3'd3, hi: 3'd2};
            5'd22: p = '{lo: 3'd4, hi: 3'd2};
            5'd23: p = '{lo: 3'd2, hi: 3'd3};
            5'd24: p = '{lo: 3'd5, hi: 3'd3};
            5'd25: p = '{lo: 3'd3, hi: 3'd5};
            5'd26: p = '{lo: 3'd5, hi: 3'd4};
            5'd27: p = '{lo: 3'd6, hi: 3'd5};
            5'd28: p = '{lo: 3'd5, hi: 3'd6};
            5'd29: p = '{lo: 3'd4, hi: 3'd6};
            5'd30: p = '{lo: 3'd6, hi: 3'd4};
            default: p = '{lo: 3'd0, hi: 3'd0};
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

### hdl/sccld_front.sv
`default_nettype none
module sccld_front import sccld_pkg::*; (
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    input  wire logic     i_full,
    output logic          o_stall,
    output logic          o_push,
    output t_cmd          o_cmd
);

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.is_tick  = (i_item.kind == KIND_TICK);
        o_cmd.is_colon = (i_item.rx_byte == CHAR_COLON);
        o_cmd.is_b     = (i_item.rx_byte == CHAR_B);
        o_cmd.nib      = hex_nibble(i_item.rx_byte);
    end

endmodule
`default_nettype wire

### hdl/sccld_queue.sv
`default_nettype none
module sccld_queue import sccld_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output t_q_head   o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full       = (r_cnt == CW'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

### hdl/sccld_back.sv
`default_nettype none
module sccld_back import sccld_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_head i_head,
    input  wire logic    i_stall,
    output logic         o_pop,
    output logic         o_valid,
    output t_out_item    o_item
);

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int IW = $clog2(STORE_DEPTH);

    logic [3:0]    r_nib [STORE_DEPTH];
    logic          r_first_b, n_first_b;
    logic          r_capturing, n_capturing;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_dig0, n_dig0;
    logic [7:0]    r_dig1, n_dig1;
    logic [7:0]    r_dig2, n_dig2;
    logic [7:0]    r_ind, n_ind;
    logic [4:0]    r_scan, n_scan;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic            take_tick, take_byte, store_en, lit;
    logic [DIGIT_BITS-1:0] digits;
    t_pin_pair       pins;

    assign take_tick = i_head.valid && i_head.cmd.is_tick && (!r_out_valid || !i_stall);
    assign take_byte = i_head.valid && !i_head.cmd.is_tick;
    assign o_pop     = take_tick || take_byte;
    assign store_en  = take_byte && r_capturing && (r_count < CW'(STORE_DEPTH));

    assign digits = {r_dig2, r_dig1, r_dig0};
    assign pins   = slot_pins(r_scan);

    always_comb begin
        if (r_scan inside {[5'd0:5'd23]}) begin
            lit = digits[r_scan];
        end else begin
            lit = r_ind[ind_of_slot(3'(r_scan - 5'd24))];
        end
    end

    always_comb begin
        n_first_b   = r_first_b;
        n_capturing = r_capturing;
        n_count     = r_count;
        n_dig0      = r_dig0;
        n_dig1      = r_dig1;
        n_dig2      = r_dig2;
        n_ind       = r_ind;
        if (take_byte) begin
            if (r_capturing) begin
                if (store_en) begin
                    n_count = r_count + 1'b1;
                    if (r_count == '0) begin
                        n_first_b = i_head.cmd.is_b;
                    end
                    if (r_count == CW'(DECODE_COUNT - 1) && r_first_b) begin
                        n_dig0      = {r_nib[2], r_nib[3]};
                        n_dig1      = {r_nib[4], r_nib[5]};
                        n_dig2      = {r_nib[6], r_nib[7]};
                        n_ind       = {r_nib[8], i_head.cmd.nib};
                        n_count     = '0;
                        n_capturing = 1'b0;
                    end
                end
            end else if (i_head.cmd.is_colon) begin
                n_capturing = 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_scan      = r_scan;
        if (take_tick) begin
            n_out_valid      = 1'b1;
            n_out.slot       = r_scan;
            n_out.drive_mask = '0;
            n_out.level_mask = '0;
            if (lit) begin
                n_out.drive_mask = (PIN_COUNT'(1) << pins.lo) | (PIN_COUNT'(1) << pins.hi);
                n_out.level_mask = PIN_COUNT'(1) << pins.hi;
            end
            n_scan = (r_scan == 5'(SLOT_COUNT - 1)) ? 5'd0 : r_scan + 5'd1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_b   <= 1'b0;
            r_capturing <= 1'b0;
            r_count     <= '0;
            r_dig0      <= '0;
            r_dig1      <= '0;
            r_dig2      <= '0;
            r_ind       <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_first_b   <= n_first_b;
            r_capturing <= n_capturing;
            r_count     <= n_count;
            r_dig0      <= n_dig0;
            r_dig1      <= n_dig1;
            r_dig2      <= n_dig2;
            r_ind       <= n_ind;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (store_en) begin
            r_nib[r_count[IW-1:0]] <= i_head.cmd.nib;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
`default_nettype wire

### hdl/serial_command_charlieplex_led_driver.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_item (kind, rx_byte)
// result    out        o_valid / i_stall  o_item (drive_mask, level_mask, slot)
//
// One transaction is accepted every cycle while the command queue is not full; a scan
// tick's result passes through the command queue and then through the output register.
// Reset is synchronous and active low; it clears capture, digits and the scan position.
// A stalled result holds the queue once a scan tick reaches its head; serial bytes
// ahead of that tick keep draining.
// The input stalls when the command queue of QUEUE_DEPTH entries is full.
`default_nettype none
module serial_command_charlieplex_led_driver import sccld_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);

    logic    q_full, push, pop;
    t_cmd    cmd;
    t_q_head head;

    sccld_front u_front (
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    sccld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    sccld_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stall (i_stall),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.slot <= 5'(SLOT_COUNT - 1)))
        else $error("Result slot out of range.");

    a_two_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones(o_item.drive_mask) == 2 || o_item.drive_mask == '0))
        else $error("A lit slot must drive exactly two pins.");

    a_level_in_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_item.level_mask & ~o_item.drive_mask) == '0
                     && $onehot0(o_item.level_mask)))
        else $error("Level set on a floating pin.");

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("Queue popped while empty.");

endmodule
`default_nettype wire

### test/led_scan_checker.sv
`timescale 1ns / 1ps
module led_scan_checker import sccld_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int STORE_LEN = STORE_DEPTH_DEF;

    localparam logic [2:0] LOW_PIN [SLOT_COUNT] = '{
        3'd0, 3'd0, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd4,
        3'd1, 3'd1, 3'd4, 3'd1, 3'd1, 3'd2, 3'd3, 3'd2,
        3'd4, 3'd2, 3'd3, 3'd5, 3'd5, 3'd3, 3'd4, 3'd2,
        3'd5, 3'd3, 3'd5, 3'd6, 3'd5, 3'd4, 3'd6
    };
    localparam logic [2:0] HIGH_PIN [SLOT_COUNT] = '{
        3'd1, 3'd2, 3'd0, 3'd0, 3'd3, 3'd0, 3'd0, 3'd5,
        3'd2, 3'd3, 3'd1, 3'd5, 3'd4, 3'd1, 3'd1, 3'd5,
        3'd3, 3'd4, 3'd4, 3'd0, 3'd2, 3'd2, 3'd2, 3'd3,
        3'd3, 3'd5, 3'd4, 3'd5, 3'd6, 3'd6, 3'd4
    };
    localparam logic [2:0] IND_ORDER [PIN_COUNT] = '{
        3'd0, 3'd2, 3'd1, 3'd3, 3'd4, 3'd5, 3'd6
    };

    logic       capturing;
    int         stored;
    logic [7:0] cmd_bytes [STORE_LEN];
    logic [7:0] digits [3];
    logic [7:0] ind_bits;
    logic [4:0] scan_pos;
    t_out_item  expected_frames [$];
    int         fails;

    assign o_fail_count = fails;

    function automatic logic [3:0] char_value(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") begin
            return 4'(ch - "0");
        end else if (ch >= "A" && ch <= "F") begin
            return 4'(ch - "A" + 10);
        end else if (ch >= "a" && ch <= "f") begin
            return 4'(ch - "a" + 10);
        end
        return 4'd0;
    endfunction

    function automatic logic [7:0] pair_value(input int hi_pos, input int lo_pos);
        return {char_value(cmd_bytes[hi_pos]), char_value(cmd_bytes[lo_pos])};
    endfunction

    task automatic take_char(input logic [7:0] ch);
        if (capturing) begin
            if (stored < STORE_LEN) begin
                cmd_bytes[stored] = ch;
                stored++;
            end
        end else if (ch == CHAR_COLON) begin
            capturing = 1'b1;
        end
        if (stored >= DECODE_COUNT && cmd_bytes[0] == CHAR_B) begin
            digits[0] = pair_value(2, 3);
            digits[1] = pair_value(4, 5);
            digits[2] = pair_value(6, 7);
            ind_bits = pair_value(8, 9);
            stored = 0;
            capturing = 1'b0;
        end
    endtask

    function automatic t_out_item scan_frame();
        t_out_item  f;
        logic [4:0] s;
        logic       lit;
        s = (scan_pos >= 5'(SLOT_COUNT)) ? 5'd0 : scan_pos;
        if (s < 5'(DIGIT_BITS)) begin
            lit = digits[s / 8][s % 8];
        end else begin
            lit = ind_bits[IND_ORDER[s - 5'(DIGIT_BITS)]];
        end
        f.drive_mask = '0;
        f.level_mask = '0;
        f.slot = s;
        if (lit) begin
            f.drive_mask[LOW_PIN[s]] = 1'b1;
            f.drive_mask[HIGH_PIN[s]] = 1'b1;
            f.level_mask[HIGH_PIN[s]] = 1'b1;
        end
        return f;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            capturing = 1'b0;
            stored = 0;
            foreach (cmd_bytes[k]) cmd_bytes[k] = 8'd0;
            foreach (digits[k]) digits[k] = 8'd0;
            ind_bits = 8'd0;
            scan_pos = 5'd0;
            fails = 0;
            expected_frames.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    $error("unexpected result: slot %0d", i_out_item.slot);
                    fails++;
                end else begin
                    want = expected_frames.pop_front();
                    if (i_out_item.drive_mask !== want.drive_mask) begin
                        $error("drive_mask: expected %h, actual %h",
                               want.drive_mask, i_out_item.drive_mask);
                        fails++;
                    end
                    if (i_out_item.level_mask !== want.level_mask) begin
                        $error("level_mask: expected %h, actual %h",
                               want.level_mask, i_out_item.level_mask);
                        fails++;
                    end
                    if (i_out_item.slot !== want.slot) begin
                        $error("slot: expected %0d, actual %0d",
                               want.slot, i_out_item.slot);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.kind == KIND_BYTE) begin
                    take_char(i_in_item.rx_byte);
                end else begin
                    want = scan_frame();
                    expected_frames.push_back(want);
                    scan_pos = (want.slot == 5'(SLOT_COUNT - 1)) ? 5'd0 : want.slot + 5'd1;
                end
            end
        end
        o_pending <= expected_frames.size();
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import sccld_pkg::*;

    localparam int RANDOM_END  = 1850;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    int        sent_count;
    int        cycle_count;
    logic      quiet;
    logic      held;
    logic      paused;

    serial_command_charlieplex_led_driver u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_item  (out_item)
    );

    led_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        out_stall = 1'b0;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && sent_count >= 400) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                out_stall <= !quiet && ($urandom_range(0, 99) < 33);
            end
        end
    end

    task automatic push_item(input logic kind, input logic [7:0] ch);
        while (!quiet && $urandom_range(0, 99) < 33) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= '{kind: kind, rx_byte: ch};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] random_digit();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) begin
            return 8'("0" + v);
        end else if (v < 16) begin
            return 8'("A" + v - 10);
        end
        return 8'("a" + v - 16);
    endfunction

    // A well-formed display command; scan ticks may fall between its bytes and
    // now and then a payload character is an arbitrary byte.
    task automatic push_command();
        logic [7:0] ch;
        push_item(KIND_BYTE, CHAR_COLON);
        push_item(KIND_BYTE, CHAR_B);
        push_item(KIND_BYTE, 8'($urandom));
        for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 99) < 25) push_item(KIND_TICK, 8'($urandom));
            ch = ($urandom_range(0, 99) < 90) ? random_digit() : 8'($urandom);
            push_item(KIND_BYTE, ch);
        end
    endtask

    initial begin
        logic [7:0] noise;
        int         pick;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        sent_count = 0;
        quiet = 1'b0;
        paused = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Blank display, ignored bytes while idle, then a command with mixed case,
        // a colon and a non-hex character among its digits.
        push_item(KIND_TICK, 8'h00);
        push_item(KIND_BYTE, 8'h00);
        push_item(KIND_BYTE, 8'hFF);
        push_item(KIND_BYTE, "x");
        push_item(KIND_BYTE, CHAR_COLON);
        push_item(KIND_BYTE, CHAR_B);
        push_item(KIND_BYTE, "?");
        push_item(KIND_BYTE, "F");
        push_item(KIND_BYTE, "f");
        push_item(KIND_BYTE, "0");
        push_item(KIND_BYTE, "9");
        push_item(KIND_BYTE, "a");
        push_item(KIND_BYTE, CHAR_COLON);
        push_item(KIND_BYTE, "A");
        push_item(KIND_BYTE, "g");
        repeat (8) push_item(KIND_TICK, 8'hFF);

        while (sent_count < RANDOM_END) begin
            quiet = (sent_count >= 900 && sent_count < 1150);
            if (!paused && sent_count >= 1300) begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(negedge i_clk);
                while (pending != 0) @(negedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                push_item(KIND_TICK, 8'($urandom));
            end else if (pick < 75) begin
                push_command();
            end else begin
                noise = 8'($urandom);
                if (noise == CHAR_COLON) noise = noise ^ 8'h01;
                push_item(KIND_BYTE, noise);
            end
        end

        // A command other than a display load is held for good: the store fills,
        // later bytes are dropped and the digits keep their last values.
        push_item(KIND_BYTE, CHAR_COLON);
        push_item(KIND_BYTE, "F");
        for (int k = 0; k < 14; k++) begin
            push_item(KIND_BYTE, 8'($urandom));
            push_item(KIND_TICK, 8'($urandom));
        end
        repeat (31) push_item(KIND_TICK, 8'($urandom));
        in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### serial_command_charlieplex_led_driver.f
hdl/sccld_pkg.sv
hdl/sccld_front.sv
hdl/sccld_queue.sv
hdl/sccld_back.sv
hdl/serial_command_charlieplex_led_driver.sv
test/led_scan_checker.sv
test/tb_top.sv
